// File: design/sc2c_pkg.sv
`timescale 1ns / 1ps
// Package for the scan-code-set-1 keyboard decoder with character FIFO.
// Holds FIFO sizing, scan code constants, op codes and the three key ROMs.
// No dependencies.
package sc2c_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;

    function automatic logic [7:0] rom_normal(input logic [6:0] key);
        logic [7:0] ch;
        case (key)
            7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h31;  7'd3:  ch = 8'h32;  7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;  7'd6:  ch = 8'h35;  7'd7:  ch = 8'h36;  7'd8:  ch = 8'h37;
            7'd9:  ch = 8'h38;  7'd10: ch = 8'h39;  7'd11: ch = 8'h30;  7'd12: ch = 8'h2B;
            7'd13: ch = 8'h27;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;  7'd16: ch = 8'h71;
            7'd17: ch = 8'h77;  7'd18: ch = 8'h65;  7'd19: ch = 8'h72;  7'd20: ch = 8'h74;
            7'd21: ch = 8'h79;  7'd22: ch = 8'h75;  7'd23: ch = 8'h69;  7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;  7'd26: ch = 8'h61;  7'd27: ch = 8'h75;  7'd28: ch = 8'h0A;
            7'd30: ch = 8'h61;  7'd31: ch = 8'h73;  7'd32: ch = 8'h64;  7'd33: ch = 8'h66;
            7'd34: ch = 8'h67;  7'd35: ch = 8'h68;  7'd36: ch = 8'h6A;  7'd37: ch = 8'h6B;
            7'd38: ch = 8'h6C;  7'd39: ch = 8'h6F;  7'd40: ch = 8'h61;  7'd41: ch = 8'h7C;
            7'd43: ch = 8'h3C;  7'd44: ch = 8'h7A;  7'd45: ch = 8'h78;  7'd46: ch = 8'h63;
            7'd47: ch = 8'h76;  7'd48: ch = 8'h62;  7'd49: ch = 8'h6E;  7'd50: ch = 8'h6D;
            7'd51: ch = 8'h2C;  7'd52: ch = 8'h2E;  7'd53: ch = 8'h2D;  7'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] rom_shift(input logic [6:0] key);
        logic [7:0] ch;
        case (key)
            7'd1:  ch = 8'h1B;  7'd2:  ch = 8'h21;  7'd3:  ch = 8'h22;  7'd4:  ch = 8'h23;
            7'd5:  ch = 8'h24;  7'd6:  ch = 8'h25;  7'd7:  ch = 8'h26;  7'd8:  ch = 8'h2F;
            7'd9:  ch = 8'h28;  7'd10: ch = 8'h29;  7'd11: ch = 8'h3D;  7'd12: ch = 8'h3F;
            7'd13: ch = 8'h60;  7'd14: ch = 8'h08;  7'd15: ch = 8'h09;  7'd16: ch = 8'h51;
            7'd17: ch = 8'h57;  7'd18: ch = 8'h45;  7'd19: ch = 8'h52;  7'd20: ch = 8'h54;
            7'd21: ch = 8'h59;  7'd22: ch = 8'h55;  7'd23: ch = 8'h49;  7'd24: ch = 8'h4F;
            7'd25: ch = 8'h50;  7'd26: ch = 8'h41;  7'd27: ch = 8'h55;  7'd28: ch = 8'h0D;
            7'd30: ch = 8'h41;  7'd31: ch = 8'h53;  7'd32: ch = 8'h44;  7'd33: ch = 8'h46;
            7'd34: ch = 8'h47;  7'd35: ch = 8'h48;  7'd36: ch = 8'h4A;  7'd37: ch = 8'h4B;
            7'd38: ch = 8'h4C;  7'd39: ch = 8'h4F;  7'd40: ch = 8'h41;  7'd41: ch = 8'h2A;
            7'd43: ch = 8'h3E;  7'd44: ch = 8'h5A;  7'd45: ch = 8'h58;  7'd46: ch = 8'h43;
            7'd47: ch = 8'h56;  7'd48: ch = 8'h42;  7'd49: ch = 8'h4E;  7'd50: ch = 8'h4D;
            7'd51: ch = 8'h3B;  7'd52: ch = 8'h3A;  7'd53: ch = 8'h5F;  7'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] rom_altgr(input logic [6:0] key);
        logic [7:0] ch;
        case (key)
            7'd3:  ch = 8'h40;  7'd4:  ch = 8'h23;  7'd5:  ch = 8'h24;  7'd8:  ch = 8'h7B;
            7'd9:  ch = 8'h5B;  7'd10: ch = 8'h5D;  7'd11: ch = 8'h7D;  7'd12: ch = 8'h5C;
            7'd18: ch = 8'h45;  7'd27: ch = 8'h7C;  7'd41: ch = 8'h7E;  7'd43: ch = 8'h3E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: design/scancode_to_char_fifo_unit.sv
`timescale 1ns / 1ps
// Scan-code-set-1 keyboard decoder with a character ring FIFO.
// Depends on sc2c_pkg (sizing, scan code constants, key ROMs).
//
// Usage:
//   Input channel (s_valid/s_ready): s_op = OP_SCAN delivers a raw keyboard
//   byte on s_scan_byte; s_op = OP_READ pops one character. Every input
//   transfer yields exactly one result transfer on m_valid/m_ready:
//   m_char_out/m_char_valid carry a popped character (0/0 on an empty read
//   or a scan byte), m_dropped flags a decoded character lost to a full FIFO.
//   Decode, modifier update and FIFO push/pop all happen at the input
//   transfer; the FIFO memory read data is registered, then the result
//   register follows, so m_valid rises once the item has passed the
//   read-data stage into the result register.
//   Throughput is one item per cycle: each item makes at most one write
//   and one read of the memory; both stages advance every cycle with m_ready.
//   When the receiver stalls, the read-data stage and the result register
//   fill up and s_ready drops; nothing is lost.
//   Reset clears modifier flags, FIFO pointers, fill count and both stage
//   valids; the character memory is not cleared (stale data is never output).
module scancode_to_char_fifo_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_char_valid,
    output logic       m_dropped
);
    import sc2c_pkg::*;

    logic [7:0]        char_mem [FIFO_DEPTH];

    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              shift_reg, shift_next;
    logic              ctrl_reg, ctrl_next;
    logic              altgr_reg, altgr_next;
    logic              prefix_reg, prefix_next;

    logic              p1_valid_reg;
    logic              p1_hit_reg;
    logic              p1_drop_reg;
    logic [7:0]        rd_data_reg;

    logic              m_valid_reg;
    logic [7:0]        m_char_out_reg;
    logic              m_char_valid_reg;
    logic              m_dropped_reg;

    logic              accept;
    logic              p1_advance;
    logic              fifo_full;
    logic              read_hit;
    logic              do_write;
    logic              drop;
    logic              released;
    logic [6:0]        key;
    logic              is_shift;
    logic              is_ctrl;
    logic              is_altgr;
    logic [7:0]        ch;

    assign p1_advance = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;
    assign fifo_full  = (fill_reg == CNT_W'(FIFO_DEPTH));

    assign released = s_scan_byte[7];
    assign key      = s_scan_byte[6:0];
    assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
    assign is_ctrl  = (key == KEY_CTRL);
    assign is_altgr = (key == KEY_ALT) && prefix_reg;

    always_comb begin
        if (altgr_reg || (ctrl_reg && prefix_reg)) begin
            ch = rom_altgr(key);
        end else if (shift_reg) begin
            ch = rom_shift(key);
        end else begin
            ch = rom_normal(key);
        end
    end

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        altgr_next  = altgr_reg;
        prefix_next = prefix_reg;
        read_hit    = 1'b0;
        do_write    = 1'b0;
        drop        = 1'b0;
        if (s_op == OP_READ) begin
            read_hit = (fill_reg != '0);
        end else if (s_scan_byte == SC_PREFIX) begin
            prefix_next = 1'b1;
        end else if (released) begin
            if (is_shift) begin
                shift_next = 1'b0;
            end else if (is_ctrl) begin
                ctrl_next = 1'b0;
            end else if (is_altgr) begin
                altgr_next = 1'b0;
            end
            prefix_next = 1'b0;
        end else if (is_shift) begin
            shift_next = 1'b1;
        end else if (is_ctrl) begin
            ctrl_next = 1'b1;
        end else if (is_altgr) begin
            altgr_next = 1'b1;
        end else begin
            prefix_next = 1'b0;
            if (ch != 8'h00) begin
                do_write = !fifo_full;
                drop     = fifo_full;
            end
        end
        if (do_write) begin
            wr_idx_next = (wr_idx_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_idx_reg + ADDR_W'(1);
            fill_next   = fill_reg + CNT_W'(1);
        end
        if (read_hit) begin
            rd_idx_next = (rd_idx_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_idx_reg + ADDR_W'(1);
            fill_next   = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            fill_reg     <= '0;
            shift_reg    <= 1'b0;
            ctrl_reg     <= 1'b0;
            altgr_reg    <= 1'b0;
            prefix_reg   <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
                fill_reg   <= fill_next;
                shift_reg  <= shift_next;
                ctrl_reg   <= ctrl_next;
                altgr_reg  <= altgr_next;
                prefix_reg <= prefix_next;
            end
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // character memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (accept && do_write) begin
            char_mem[wr_idx_reg] <= ch;
        end
        if (accept) begin
            rd_data_reg <= char_mem[rd_idx_reg];
            p1_hit_reg  <= read_hit;
            p1_drop_reg <= drop;
        end
        if (p1_advance) begin
            m_char_out_reg   <= p1_hit_reg ? rd_data_reg : 8'h00;
            m_char_valid_reg <= p1_hit_reg;
            m_dropped_reg    <= p1_drop_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_char_out   = m_char_out_reg;
    assign m_char_valid = m_char_valid_reg;
    assign m_dropped    = m_dropped_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fill count above FIFO depth");

    a_valid_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> m_char_out != 8'h00)
        else $error("popped character is zero");

    a_drop_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && drop |-> fifo_full && !do_write)
        else $error("drop without full FIFO");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && read_hit |=> fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("pop did not decrement fill count");

    a_read_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> !m_char_valid)
        else $error("drop and character in one result");

endmodule

// File: tb/sc2c_result_checker.sv
`timescale 1ns / 1ps
// Result checker for scancode_to_char_fifo_unit: watches both channels, decodes every
// accepted transfer with its own keyboard state and character queue, compares each result.
// Depends on sc2c_pkg for op codes, scan code constants and FIFO_DEPTH.
module sc2c_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_scan_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_char_out,
    input  logic       m_char_valid,
    input  logic       m_dropped,
    output int         mismatches,
    output int         awaited,
    output int         results_checked,
    output int         chars_read,
    output int         chars_dropped
);
    import sc2c_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       dropped;
    } key_result_t;

    localparam logic [0:57][7:0] PLAIN_MAP = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2B, 8'h27, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h61, 8'h75, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6F,
        8'h61, 8'h7C, 8'h00, 8'h3C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h00,
        8'h00, 8'h20
    };

    localparam logic [0:57][7:0] SHIFT_MAP = {
        8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h41, 8'h55, 8'h0D, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4F,
        8'h41, 8'h2A, 8'h00, 8'h3E, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h00,
        8'h00, 8'h20
    };

    localparam logic [0:43][7:0] ALTGR_MAP = {
        8'h00, 8'h00, 8'h00, 8'h40, 8'h23, 8'h24, 8'h00, 8'h00,
        8'h7B, 8'h5B, 8'h5D, 8'h7D, 8'h5C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h7E, 8'h00, 8'h3E
    };

    logic [7:0]  held_chars[$];
    key_result_t awaited_results[$];
    logic        shift_down;
    logic        ctrl_down;
    logic        altgr_down;
    logic        prefix_seen;
    int          error_total;
    int          checked_total;
    int          read_total;
    int          drop_total;

    function automatic logic [7:0] plain_char(input logic [6:0] key);
        return (key < 7'd58) ? PLAIN_MAP[key] : 8'h00;
    endfunction

    function automatic logic [7:0] shift_char(input logic [6:0] key);
        return (key < 7'd58) ? SHIFT_MAP[key] : 8'h00;
    endfunction

    function automatic logic [7:0] altgr_char(input logic [6:0] key);
        return (key < 7'd44) ? ALTGR_MAP[key] : 8'h00;
    endfunction

    function automatic key_result_t decode_item(input logic op, input logic [7:0] code);
        key_result_t res;
        logic [6:0]  key;
        logic        is_shift;
        logic [7:0]  ch;
        res      = '0;
        key      = code[6:0];
        is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
        if (op == OP_READ) begin
            if (held_chars.size() != 0) begin
                res.ch       = held_chars.pop_front();
                res.ch_valid = 1'b1;
            end
        end else if (code == SC_PREFIX) begin
            prefix_seen = 1'b1;
        end else if (code[7]) begin
            if (is_shift) begin
                shift_down = 1'b0;
            end else if (key == KEY_CTRL) begin
                ctrl_down = 1'b0;
            end else if (key == KEY_ALT && prefix_seen) begin
                altgr_down = 1'b0;
            end
            prefix_seen = 1'b0;
        end else if (is_shift) begin
            shift_down = 1'b1;
        end else if (key == KEY_CTRL) begin
            ctrl_down = 1'b1;
        end else if (key == KEY_ALT && prefix_seen) begin
            altgr_down = 1'b1;
        end else begin
            if (altgr_down || (ctrl_down && prefix_seen)) begin
                ch = altgr_char(key);
            end else if (shift_down) begin
                ch = shift_char(key);
            end else begin
                ch = plain_char(key);
            end
            prefix_seen = 1'b0;
            if (ch != 8'h00) begin
                if (held_chars.size() >= FIFO_DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    held_chars.push_back(ch);
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (exp_val !== got_val) begin
            error_total++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val,
                     got_val);
        end
    endtask

    always @(posedge aclk) begin
        key_result_t want;
        if (!aresetn) begin
            held_chars.delete();
            awaited_results.delete();
            shift_down  = 1'b0;
            ctrl_down   = 1'b0;
            altgr_down  = 1'b0;
            prefix_seen = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    error_total++;
                    $display("%0t: result with none expected, got char %h valid %b dropped %b",
                             $time, m_char_out, m_char_valid, m_dropped);
                end else begin
                    want = awaited_results.pop_front();
                    checked_total++;
                    if (want.ch_valid) read_total++;
                    if (want.dropped) drop_total++;
                    check_field("char_out", want.ch, m_char_out);
                    check_field("char_valid", {7'd0, want.ch_valid}, {7'd0, m_char_valid});
                    check_field("dropped", {7'd0, want.dropped}, {7'd0, m_dropped});
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(decode_item(s_op, s_scan_byte));
            end
        end
        mismatches      <= error_total;
        awaited         <= awaited_results.size();
        results_checked <= checked_total;
        chars_read      <= read_total;
        chars_dropped   <= drop_total;
    end

endmodule

// File: tb/scancode_to_char_fifo_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for scancode_to_char_fifo_unit: drives scan code and read transfers,
// random backpressure, a long receiver hold-off and a full-buffer burst; gives the verdict.
// Depends on sc2c_pkg, scancode_to_char_fifo_unit and sc2c_result_checker.
module scancode_to_char_fifo_unit_tb;
    import sc2c_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [0:11][6:0] ALTGR_KEYS = {
        7'd3, 7'd4, 7'd5, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd18, 7'd27, 7'd41, 7'd43
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_op        = OP_SCAN;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_char_out;
    logic       m_char_valid;
    logic       m_dropped;

    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    logic no_idle    = 1'b0;
    int   hold_left  = 0;
    int   quiet      = 0;
    int   items_sent = 0;

    int mismatches;
    int awaited;
    int results_checked;
    int chars_read;
    int chars_dropped;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    scancode_to_char_fifo_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_scan_byte  (s_scan_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_char_valid (m_char_valid),
        .m_dropped    (m_dropped)
    );

    sc2c_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_scan_byte     (s_scan_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_out      (m_char_out),
        .m_char_valid    (m_char_valid),
        .m_dropped       (m_dropped),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .chars_read      (chars_read),
        .chars_dropped   (chars_dropped)
    );

    // receiver: random stalls, one long hold-off once requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] make_code(input logic [6:0] key);
        return {1'b0, key};
    endfunction

    function automatic logic [7:0] break_code(input logic [6:0] key);
        return {1'b1, key};
    endfunction

    function automatic logic [6:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 7'($urandom_range(0, 127));
        if (r < 40) return ALTGR_KEYS[$urandom_range(0, 11)];
        return 7'($urandom_range(1, 57));
    endfunction

    function automatic logic [6:0] pick_shift();
        return $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
    endfunction

    task automatic push_item(input logic op, input logic [7:0] code);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_scan_byte <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 36) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
    endtask

    task automatic type_sequence(input int read_pct);
        logic [6:0] k;
        logic [6:0] sh;
        if ($urandom_range(0, 99) < read_pct) push_item(OP_READ, 8'($urandom_range(0, 255)));
        k  = pick_key();
        sh = pick_shift();
        case ($urandom_range(0, 7))
            0, 1: begin
                push_item(OP_SCAN, make_code(k));
                if ($urandom_range(0, 1)) push_item(OP_SCAN, break_code(k));
            end
            2: begin
                push_item(OP_SCAN, make_code(sh));
                push_item(OP_SCAN, make_code(k));
                push_item(OP_SCAN, break_code(sh));
            end
            3: begin
                push_item(OP_SCAN, SC_PREFIX);
                push_item(OP_SCAN, make_code(KEY_ALT));
                push_item(OP_SCAN, make_code(k));
                push_item(OP_SCAN, SC_PREFIX);
                push_item(OP_SCAN, break_code(KEY_ALT));
            end
            4: begin
                push_item(OP_SCAN, make_code(KEY_CTRL));
                push_item(OP_SCAN, SC_PREFIX);
                push_item(OP_SCAN, make_code(k));
                push_item(OP_SCAN, break_code(KEY_CTRL));
            end
            5: begin
                push_item(OP_SCAN, SC_PREFIX);
                push_item(OP_SCAN, make_code(k));
                push_item(OP_SCAN, SC_PREFIX);
                push_item(OP_SCAN, break_code(k));
            end
            6: push_item(OP_SCAN, 8'($urandom_range(0, 255)));
            default: begin
                // broken sequences: stray prefix or a modifier left held
                case ($urandom_range(0, 3))
                    0: push_item(OP_SCAN, SC_PREFIX);
                    1: push_item(OP_SCAN, make_code(sh));
                    2: push_item(OP_SCAN, make_code(KEY_CTRL));
                    default: begin
                        push_item(OP_SCAN, SC_PREFIX);
                        push_item(OP_SCAN, make_code(KEY_ALT));
                    end
                endcase
            end
        endcase
    endtask

    task automatic type_until(input int target, input int read_pct);
        while (items_sent < target) type_sequence(read_pct);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(OP_READ, 8'hFF);
        push_item(OP_SCAN, 8'h00);
        push_item(OP_SCAN, 8'h1E);
        push_item(OP_SCAN, make_code(KEY_LSHIFT));
        push_item(OP_SCAN, 8'h02);
        push_item(OP_SCAN, break_code(KEY_LSHIFT));
        push_item(OP_SCAN, make_code(KEY_RSHIFT));
        push_item(OP_SCAN, 8'h10);
        push_item(OP_SCAN, break_code(KEY_RSHIFT));
        // ctrl press keeps the prefix, so the next key decodes as altgr
        push_item(OP_SCAN, SC_PREFIX);
        push_item(OP_SCAN, make_code(KEY_CTRL));
        push_item(OP_SCAN, 8'h03);
        push_item(OP_SCAN, break_code(KEY_CTRL));
        push_item(OP_SCAN, SC_PREFIX);
        push_item(OP_SCAN, make_code(KEY_ALT));
        push_item(OP_SCAN, 8'h08);
        push_item(OP_SCAN, SC_PREFIX);
        push_item(OP_SCAN, break_code(KEY_ALT));
        push_item(OP_SCAN, make_code(KEY_ALT));
        push_item(OP_SCAN, break_code(KEY_ALT));
        push_item(OP_SCAN, 8'h7F);
        push_item(OP_SCAN, 8'hFF);
        push_item(OP_SCAN, SC_PREFIX);
        push_item(OP_SCAN, 8'h39);
        repeat (5) push_item(OP_READ, 8'h00);
        wait_for_results();

        type_until(items_sent + 600, 30);

        hold_req <= 1'b1;
        type_until(items_sent + 60, 30);

        // full buffer: clear modifiers, overfill with letters, then drain past empty
        no_idle <= 1'b1;
        push_item(OP_SCAN, break_code(KEY_LSHIFT));
        push_item(OP_SCAN, break_code(KEY_RSHIFT));
        push_item(OP_SCAN, break_code(KEY_CTRL));
        push_item(OP_SCAN, SC_PREFIX);
        push_item(OP_SCAN, break_code(KEY_ALT));
        repeat (FIFO_DEPTH + 20) push_item(OP_SCAN, make_code(7'($urandom_range(16, 25))));
        repeat (FIFO_DEPTH + 8) push_item(OP_READ, 8'($urandom_range(0, 255)));
        no_idle <= 1'b0;
        wait_for_results();

        type_until(items_sent + 1000, 40);
        repeat (FIFO_DEPTH + 8) push_item(OP_READ, 8'($urandom_range(0, 255)));

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d transfers, checked %0d results.", items_sent, results_checked);
        $display("Characters read back: %0d, lost to a full buffer: %0d.", chars_read,
                 chars_dropped);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
